// File: rtl/assert_macros.svh
// Assertion macros used by the RTL top level; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg)
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

// File: rtl/vsr_pkg.sv
// Shared widths, register indexes and bundle types of the volume address generator.
package vsr_pkg;

  localparam int DIM_BITS      = 11;
  localparam int COORD_BITS    = 11;
  localparam int SHIFT_BITS    = 12;
  localparam int INDEX_BITS    = 30;
  localparam int AREA_BITS     = 2 * DIM_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_X   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_Y   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_Z   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_Z = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_REVERSE = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLED = 3'd7;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } vsr_coord_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]  dim_x;
    logic [AREA_BITS-1:0] area_xy;
  } vsr_geom_t;

endpackage

// File: rtl/vsr_offset.sv
// Iterative remainder unit: shift mod dim, one quotient bit per cycle.
module vsr_offset
  import vsr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [SHIFT_BITS-1:0] shift,
  input  logic [DIM_BITS-1:0]          dim,
  output logic                         busy,
  output logic [COORD_BITS-1:0]        offset
);

  localparam int STEP_BITS = $clog2(SHIFT_BITS + 1);

  logic [STEP_BITS-1:0]  cnt;
  logic [SHIFT_BITS-1:0] mag;
  logic                  neg;
  logic [DIM_BITS-1:0]   rem;
  logic [DIM_BITS-1:0]   divisor;

  logic [DIM_BITS:0]     trial;
  logic [DIM_BITS-1:0]   rem_next;

  always_comb begin
    trial = {rem, mag[SHIFT_BITS-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = DIM_BITS'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[DIM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      offset <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      cnt     <= STEP_BITS'(SHIFT_BITS);
      // magnitude as unsigned; the most negative shift maps onto its own pattern
      mag     <= shift[SHIFT_BITS-1] ? SHIFT_BITS'(-shift) : SHIFT_BITS'(shift);
      neg     <= shift[SHIFT_BITS-1];
      rem     <= '0;
      divisor <= dim;
    end else if (busy) begin
      rem <= rem_next;
      mag <= mag << 1;
      cnt <= cnt - STEP_BITS'(1);
      if (cnt == STEP_BITS'(1)) begin
        busy <= 1'b0;
        // true modulo: a negative shift with a remainder folds back into range
        if (neg && (rem_next != '0)) begin
          offset <= COORD_BITS'(divisor - rem_next);
        end else begin
          offset <= COORD_BITS'(rem_next);
        end
      end
    end
  end

endmodule

// File: rtl/vsr_index_pipe.sv
// Index pipeline: coordinate register, product register, output word register.
module vsr_index_pipe
  import vsr_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  vsr_coord_t            coord,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  last,
  input  vsr_geom_t             geom,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_BITS-1:0] dest_index,
  output logic [VALUE_BITS-1:0] value_out,
  output logic                  last_out
);

  localparam int PLANE_BITS = COORD_BITS + AREA_BITS;

  logic                  advance;

  logic                  a_valid;
  vsr_coord_t            a_coord;
  logic [VALUE_BITS-1:0] a_value;
  logic                  a_last;

  logic                  b_valid;
  logic [COORD_BITS-1:0] b_x;
  logic [AREA_BITS-1:0]  b_row;
  logic [INDEX_BITS-1:0] b_plane;
  logic [VALUE_BITS-1:0] b_value;
  logic                  b_last;

  logic [AREA_BITS-1:0]             row_prod;
  logic [PLANE_BITS-1:0]            plane_prod;

  assign advance = !out_valid || out_ready;
  assign ready   = advance;

  assign row_prod   = AREA_BITS'(a_coord.y) * AREA_BITS'(geom.dim_x);
  assign plane_prod = PLANE_BITS'(a_coord.z) * PLANE_BITS'(geom.area_xy);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_coord    <= coord;
      a_value    <= value;
      a_last     <= last;
      b_x        <= a_coord.x;
      b_row      <= row_prod;
      b_plane    <= plane_prod[INDEX_BITS-1:0];
      b_value    <= a_value;
      b_last     <= a_last;
      dest_index <= b_plane + INDEX_BITS'(b_row) + INDEX_BITS'(b_x);
      value_out  <= b_value;
      last_out   <= b_last;
    end
  end

endmodule

// File: rtl/volume_shift_reverse_addr_gen.sv
// Volume address generator: periodic shift and axis reversal of raster voxel positions.
// Path: an accepted input word passes the coordinate, product and output word registers.
// Throughput: one word per cycle while m_tready holds and no remainder unit is busy; the
// position counters and index pipeline take a word every cycle. A dim or shift write starts
// the remainder units, which hold off both channels until their offsets are ready.
// Reset: dims 1, shifts 0, no reversal, enabled, counters at zero, pipeline empty.
`include "assert_macros.svh"
module volume_shift_reverse_addr_gen
  import vsr_pkg::*;
#(
  parameter int DIM_MAX    = 1024,
  parameter int VALUE_BITS = 32,
  localparam int IN_W  = ((VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((INDEX_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_W-1:0]          s_tdata,   // voxel_value
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_W-1:0]         m_tdata,   // dest_index, value_out
  output logic                     m_tlast,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int DIM_CAP = (DIM_MAX > (1 << DIM_BITS) - 1) ? (1 << DIM_BITS) - 1 : DIM_MAX;
  localparam int PW      = $clog2(DIM_CAP);

  logic [DIM_BITS-1:0]          dim_x, dim_y, dim_z;
  logic signed [SHIFT_BITS-1:0] shift_x, shift_y, shift_z;
  logic [2:0]                   reverse_mask;
  logic                         enabled;
  logic [AREA_BITS-1:0]         area_xy;

  logic [PW-1:0]                pos_x, pos_y, pos_z;
  logic                         start_q;

  logic                         cfg_we, accept, busy, pipe_ready;
  logic                         busy_x, busy_y, busy_z;
  logic [COORD_BITS-1:0]        off_x, off_y, off_z;
  logic [DIM_BITS-1:0]          dim_eff;
  logic                         x_end, y_end, z_end;
  logic [COORD_BITS-1:0]        px, py, pz;
  vsr_coord_t                   coord;
  vsr_geom_t                    geom;
  logic [INDEX_BITS-1:0]        dest_index;
  logic [VALUE_BITS-1:0]        value_out;

  function automatic logic [COORD_BITS-1:0] map_axis(
    input logic [COORD_BITS-1:0] p,
    input logic [COORD_BITS-1:0] off,
    input logic [DIM_BITS-1:0]   dim,
    input logic                  rev,
    input logic                  en
  );
    logic [COORD_BITS:0]   s;
    logic [COORD_BITS-1:0] w;
    s = {1'b0, p} + {1'b0, off};
    if (s >= {1'b0, dim}) begin
      w = COORD_BITS'(s - {1'b0, dim});
    end else begin
      w = s[COORD_BITS-1:0];
    end
    if (rev) begin
      w = dim - COORD_BITS'(1) - w;
    end
    return en ? w : p;
  endfunction

  assign busy      = start_q || busy_x || busy_y || busy_z;
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign s_tready  = pipe_ready && !busy;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    if (cfg_data[DIM_BITS-1:0] == '0) begin
      dim_eff = DIM_BITS'(1);
    end else if (cfg_data[DIM_BITS-1:0] > DIM_BITS'(DIM_CAP)) begin
      dim_eff = DIM_BITS'(DIM_CAP);
    end else begin
      dim_eff = cfg_data[DIM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x        <= DIM_BITS'(1);
      dim_y        <= DIM_BITS'(1);
      dim_z        <= DIM_BITS'(1);
      shift_x      <= '0;
      shift_y      <= '0;
      shift_z      <= '0;
      reverse_mask <= '0;
      enabled      <= 1'b1;
      start_q      <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_DIM_X: begin
            dim_x   <= dim_eff;
            start_q <= 1'b1;
          end
          REG_DIM_Y: begin
            dim_y   <= dim_eff;
            start_q <= 1'b1;
          end
          REG_DIM_Z: begin
            dim_z   <= dim_eff;
            start_q <= 1'b1;
          end
          REG_SHIFT_X: begin
            shift_x <= cfg_data;
            start_q <= 1'b1;
          end
          REG_SHIFT_Y: begin
            shift_y <= cfg_data;
            start_q <= 1'b1;
          end
          REG_SHIFT_Z: begin
            shift_z <= cfg_data;
            start_q <= 1'b1;
          end
          REG_REVERSE: reverse_mask <= cfg_data[2:0];
          REG_ENABLED: enabled      <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // plane size for the z term, refreshed every cycle
  always_ff @(posedge clk) begin
    area_xy <= AREA_BITS'(dim_x) * AREA_BITS'(dim_y);
  end

  assign px    = COORD_BITS'(pos_x);
  assign py    = COORD_BITS'(pos_y);
  assign pz    = COORD_BITS'(pos_z);
  assign x_end = px == dim_x - DIM_BITS'(1);
  assign y_end = py == dim_y - DIM_BITS'(1);
  assign z_end = pz == dim_z - DIM_BITS'(1);

  // raster position of the next voxel; a geometry write restarts the volume
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (cfg_we && (cfg_index == REG_DIM_X || cfg_index == REG_DIM_Y ||
                            cfg_index == REG_DIM_Z)) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      if (x_end) begin
        pos_x <= '0;
        if (y_end) begin
          pos_y <= '0;
          if (z_end) begin
            pos_z <= '0;
          end else begin
            pos_z <= pos_z + PW'(1);
          end
        end else begin
          pos_y <= pos_y + PW'(1);
        end
      end else begin
        pos_x <= pos_x + PW'(1);
      end
    end
  end

  vsr_offset u_off_x (
    .clk    (clk),
    .rst    (rst),
    .start  (start_q),
    .shift  (shift_x),
    .dim    (dim_x),
    .busy   (busy_x),
    .offset (off_x)
  );

  vsr_offset u_off_y (
    .clk    (clk),
    .rst    (rst),
    .start  (start_q),
    .shift  (shift_y),
    .dim    (dim_y),
    .busy   (busy_y),
    .offset (off_y)
  );

  vsr_offset u_off_z (
    .clk    (clk),
    .rst    (rst),
    .start  (start_q),
    .shift  (shift_z),
    .dim    (dim_z),
    .busy   (busy_z),
    .offset (off_z)
  );

  assign coord.x       = map_axis(px, off_x, dim_x, reverse_mask[0], enabled);
  assign coord.y       = map_axis(py, off_y, dim_y, reverse_mask[1], enabled);
  assign coord.z       = map_axis(pz, off_z, dim_z, reverse_mask[2], enabled);
  assign geom.dim_x    = dim_x;
  assign geom.area_xy  = area_xy;

  vsr_index_pipe #(
    .VALUE_BITS (VALUE_BITS)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .coord      (coord),
    .value      (s_tdata[VALUE_BITS-1:0]),
    .last       (x_end && y_end && z_end),
    .geom       (geom),
    .ready      (pipe_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .dest_index (dest_index),
    .value_out  (value_out),
    .last_out   (m_tlast)
  );

  assign m_tdata = OUT_W'({value_out, dest_index});

  `ASSERT_ALWAYS(a_pos_in_range, clk, rst,
                 (px < dim_x) && (py < dim_y) && (pz < dim_z),
                 "position counter outside volume")
  `ASSERT_NEXT(a_last_wraps, clk, rst, accept && x_end && y_end && z_end,
               (pos_x == '0) && (pos_y == '0) && (pos_z == '0),
               "counters did not wrap after last voxel")
  `ASSERT_IMPLIES(a_offset_range, clk, rst, !busy,
                  (off_x < dim_x) && (off_y < dim_y) && (off_z < dim_z),
                  "shift offset not reduced below dimension")

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the volume shift and reverse address generator.
`timescale 1ns / 1ps
module testbench;
  import vsr_pkg::*;

  localparam int LATENCY       = 3;
  localparam int VOXEL_TARGET  = 1320;
  localparam int CALM_TAIL     = 150;
  localparam int STALL_LIMIT   = 2000;

  typedef struct {
    logic [INDEX_BITS-1:0] index;
    logic [31:0]           value;
    logic                  last;
  } dest_word_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [31:0]              s_tdata;   // voxel_value
  logic                     m_tvalid;
  logic                     m_tready;
  logic [63:0]              m_tdata;   // dest_index, value_out
  logic                     m_tlast;   // last_voxel
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  volume_shift_reverse_addr_gen DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers and raster position
  int unsigned           vol_dx, vol_dy, vol_dz;
  logic signed [11:0]    sh_x, sh_y, sh_z;
  logic [2:0]            flip_mask;
  logic                  map_on;
  int unsigned           at_x, at_y, at_z;

  dest_word_t  pending_dests[$];
  int unsigned errors;
  int unsigned voxels_sent;
  int unsigned words_checked;
  int unsigned volumes_closed;
  int unsigned reg_writes;
  int unsigned idle_cycles;
  int unsigned hold_cnt;
  bit          bursts_on;

  function automatic int unsigned clamp_dim(logic [10:0] raw);
    if (raw == 11'd0) return 1;
    if (raw > 11'd1024) return 1024;
    return 32'(raw);
  endfunction

  // periodic shift with true modulo, result in 0..d-1
  function automatic int unsigned wrap_coord(int unsigned p, logic signed [11:0] s,
                                             int unsigned d);
    int v;
    int r;
    v = int'(p) + int'(s);
    r = v % int'(d);
    if (r < 0) r += int'(d);
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_DIM_X:   vol_dx = clamp_dim(data[10:0]);
      REG_DIM_Y:   vol_dy = clamp_dim(data[10:0]);
      REG_DIM_Z:   vol_dz = clamp_dim(data[10:0]);
      REG_SHIFT_X: sh_x = data;
      REG_SHIFT_Y: sh_y = data;
      REG_SHIFT_Z: sh_z = data;
      REG_REVERSE: flip_mask = data[2:0];
      REG_ENABLED: map_on = data[0];
      default: ;
    endcase
    // any geometry write restarts the volume
    if (idx == REG_DIM_X || idx == REG_DIM_Y || idx == REG_DIM_Z) begin
      at_x = 0;
      at_y = 0;
      at_z = 0;
    end
  endfunction

  function automatic void predict_dest(logic [31:0] value);
    dest_word_t  w;
    int unsigned x, y, z;
    longint      idx;
    bit          end_x, end_y, end_z;
    x = at_x;
    y = at_y;
    z = at_z;
    if (map_on) begin
      x = wrap_coord(x, sh_x, vol_dx);
      y = wrap_coord(y, sh_y, vol_dy);
      z = wrap_coord(z, sh_z, vol_dz);
      if (flip_mask[0]) x = vol_dx - 1 - x;
      if (flip_mask[1]) y = vol_dy - 1 - y;
      if (flip_mask[2]) z = vol_dz - 1 - z;
    end
    idx = longint'(x) + longint'(y) * vol_dx + longint'(z) * vol_dx * vol_dy;
    end_x = (at_x + 1 >= vol_dx);
    end_y = (at_y + 1 >= vol_dy);
    end_z = (at_z + 1 >= vol_dz);
    w.index = idx[INDEX_BITS-1:0];
    w.value = value;
    w.last  = end_x && end_y && end_z;
    pending_dests.push_back(w);
    if (end_x) begin
      at_x = 0;
      if (end_y) begin
        at_y = 0;
        at_z = end_z ? 0 : at_z + 1;
      end else begin
        at_y++;
      end
    end else begin
      at_x++;
    end
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h, expected %0h (word %0d)", what, got, want,
             words_checked);
    errors++;
  endtask

  // one voxel word; valid stays high between back-to-back words
  task automatic send_voxel(logic [31:0] value);
    // no idling on either side over the last stretch of the run
    if (voxels_sent + CALM_TAIL >= VOXEL_TARGET) bursts_on = 1'b0;
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    predict_dest(value);
    voxels_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    reg_writes++;
  endtask

  task automatic cfg_close();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop the stream and wait for every outstanding word
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_dests.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    dest_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_dests.size() == 0) begin
        $display("unexpected output word: %0h last %0b", m_tdata, m_tlast);
        errors++;
      end else begin
        w = pending_dests.pop_front();
        if (m_tdata[INDEX_BITS-1:0] !== w.index)
          report("dest_index", longint'(m_tdata[INDEX_BITS-1:0]), longint'(w.index));
        if (m_tdata[INDEX_BITS+31:INDEX_BITS] !== w.value)
          report("value_out", longint'(m_tdata[INDEX_BITS+31:INDEX_BITS]),
                 longint'(w.value));
        if (m_tlast !== w.last)
          report("last_voxel", longint'(m_tlast), longint'(w.last));
        if (w.last) volumes_closed++;
      end
      words_checked++;
    end
  end

  // output back-pressure in bursts
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= (hold_cnt == 1);
    end else if (bursts_on && $urandom_range(0, 11) == 0) begin
      hold_cnt <= $urandom_range(1, 16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // after reset every voxel of a 1x1x1 volume maps to zero and is last
  task automatic test_reset_state();
    send_voxel(32'h0000_0000);
    send_voxel(32'hFFFF_FFFF);
    send_voxel(32'h5555_5555);
    send_voxel(32'hAAAA_AAAA);
    drain();
  endtask

  // zero and oversize dims, shifts of -1, and the top of the index range
  task automatic test_dim_limits();
    write_reg(REG_DIM_X, 12'd0);
    write_reg(REG_DIM_Y, 12'd2047);
    write_reg(REG_DIM_Z, 12'd1);
    write_reg(REG_SHIFT_Y, 12'hFFF);
    write_reg(REG_REVERSE, 12'd2);
    cfg_close();
    send_voxel($urandom());
    send_voxel($urandom());
    drain();
    write_reg(REG_DIM_X, 12'd1024);
    write_reg(REG_DIM_Y, 12'd1024);
    write_reg(REG_DIM_Z, 12'd1024);
    write_reg(REG_SHIFT_X, 12'hFFF);
    write_reg(REG_SHIFT_Z, 12'hFFF);
    write_reg(REG_REVERSE, 12'd0);
    cfg_close();
    send_voxel($urandom());
    drain();
    write_reg(REG_REVERSE, 12'd7);
    cfg_close();
    send_voxel($urandom());
    drain();
  endtask

  // shifts at the ends of their range, partial reversal, then pass-through
  task automatic test_shift_reverse();
    write_reg(REG_DIM_X, 12'd3);
    write_reg(REG_DIM_Y, 12'd2);
    write_reg(REG_DIM_Z, 12'd1);
    write_reg(REG_SHIFT_X, 12'h800);
    write_reg(REG_SHIFT_Y, 12'h7FF);
    write_reg(REG_SHIFT_Z, 12'd5);
    write_reg(REG_REVERSE, 12'd5);
    cfg_close();
    repeat (6) send_voxel($urandom());
    drain();
    write_reg(REG_ENABLED, 12'd0);
    cfg_close();
    repeat (4) send_voxel($urandom());
    drain();
  endtask

  // dim write mid-volume restarts the raster
  task automatic test_geometry_restart();
    write_reg(REG_ENABLED, 12'd1);
    write_reg(REG_DIM_X, 12'd2);
    write_reg(REG_DIM_Y, 12'd2);
    cfg_close();
    send_voxel($urandom());
    send_voxel($urandom());
    drain();
    write_reg(REG_DIM_Z, 12'd1);
    cfg_close();
    send_voxel($urandom());
    send_voxel($urandom());
    drain();
  endtask

  function automatic logic [11:0] pick_dim_raw();
    logic [11:0] raw;
    if ($urandom_range(0, 9) == 0) raw = 12'($urandom_range(0, 4095));
    else raw = 12'($urandom_range(1, 6) | ($urandom_range(0, 1) << 11));
    return raw;
  endfunction

  function automatic logic [11:0] pick_shift(int unsigned d);
    int s;
    if ($urandom_range(0, 3) == 0) return 12'($urandom_range(0, 4095));
    s = int'($urandom_range(0, 2 * d)) - int'(d);
    return s[11:0];
  endfunction

  task automatic test_random_volumes();
    int unsigned vol;
    int unsigned n;
    while (voxels_sent < VOXEL_TARGET) begin
      drain();
      bursts_on = (voxels_sent + CALM_TAIL < VOXEL_TARGET) && ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 2) != 0) begin
        write_reg(REG_DIM_X, pick_dim_raw());
        write_reg(REG_DIM_Y, pick_dim_raw());
        write_reg(REG_DIM_Z, pick_dim_raw());
      end
      if ($urandom_range(0, 2) != 0) write_reg(REG_SHIFT_X, pick_shift(vol_dx));
      if ($urandom_range(0, 2) != 0) write_reg(REG_SHIFT_Y, pick_shift(vol_dy));
      if ($urandom_range(0, 2) != 0) write_reg(REG_SHIFT_Z, pick_shift(vol_dz));
      if ($urandom_range(0, 2) != 0) write_reg(REG_REVERSE, 12'($urandom_range(0, 7)));
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_ENABLED,
                  12'(($urandom_range(0, 3) != 0) | ($urandom_range(0, 2047) << 1)));
      cfg_close();
      vol = vol_dx * vol_dy * vol_dz;
      // huge volumes only get a short stretch of voxels
      if (vol > 216) n = $urandom_range(1, 48);
      else case ($urandom_range(0, 3))
        0:       n = $urandom_range(1, vol);
        1:       n = 2 * vol;
        default: n = vol;
      endcase
      if (n > VOXEL_TARGET - voxels_sent) n = VOXEL_TARGET - voxels_sent;
      repeat (n) send_voxel($urandom());
    end
    drain();
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DIM_X;
    cfg_data  = '0;
    hold_cnt  = 0;
    bursts_on = 1'b1;
    errors = 0; voxels_sent = 0; words_checked = 0; volumes_closed = 0;
    reg_writes = 0; idle_cycles = 0;
    vol_dx = 1; vol_dy = 1; vol_dz = 1;
    sh_x = '0; sh_y = '0; sh_z = '0;
    flip_mask = '0; map_on = 1'b1;
    at_x = 0; at_y = 0; at_z = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_dim_limits();
    test_shift_reverse();
    test_geometry_restart();
    test_random_volumes();

    repeat (LATENCY + 5) @(posedge clk);
    $display("covered %0d voxels, %0d output words, %0d full volumes, %0d register writes",
             voxels_sent, words_checked, volumes_closed, reg_writes);
    $display("mismatches: %0d, words still outstanding: %0d", errors, pending_dests.size());
    if (errors == 0 && pending_dests.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
